>>> sv/orl_pkg.sv
// Shared types, constants and command structures for the ordered record list.
package orl_pkg;

	// Capacity of the list and derived index widths.
	localparam int DEPTH = 32;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	// Fixed field widths of the item and result ports.
	localparam int MODE_W = 4;
	localparam int POS_W = 6;
	localparam int ID_W = 32;
	localparam int GRADE_W = 32;
	localparam int STAT_W = 2;
	localparam int OCNT_W = 6;

	// Width that holds both a position and a length plus one without overflow.
	localparam int CMP_W = CNT_W + POS_W;

	// Operation codes carried by the mode field.
	typedef enum logic [MODE_W-1:0] {
		MODE_CLEAR     = 4'd0,
		MODE_INS_FRONT = 4'd1,
		MODE_INS_BACK  = 4'd2,
		MODE_INS_AT    = 4'd3,
		MODE_DEL_FRONT = 4'd4,
		MODE_DEL_BACK  = 4'd5,
		MODE_DEL_AT    = 4'd6,
		MODE_SEARCH    = 4'd7,
		MODE_COUNT     = 4'd8,
		MODE_DUMP      = 4'd9
	} mode_t;

	// Status codes of a result.
	typedef enum logic [STAT_W-1:0] {
		STAT_OK    = 2'd0,
		STAT_FULL  = 2'd1,
		STAT_EMPTY = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic {
		ST_IDLE,
		ST_WALK
	} state_t;

	// Operation broadcast to every cell of the chain.
	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_INS,
		CELL_DEL,
		CELL_ROT
	} cell_op_t;

	typedef struct packed {
		cell_op_t         op;
		logic [IDX_W-1:0] k;
		logic [IDX_W-1:0] last_idx;
	} cell_cmd_t;

endpackage

>>> sv/ordered_record_list.sv
// Top level of the ordered record list: controller and a chain of record cells.
//
// Input channel: in_valid / in_stall carry one operation item (mode, position,
// record_id, record_grade). Output channel: out_valid / out_stall carry result
// items (status, found, entry_count, out_id, out_grade, last).
// Clear, insert, delete, count and unused modes update the chain when the item
// is accepted and give one result in the cycle after acceptance.
// Search and dump rotate the list once through the head cell, one entry per
// cycle while the output is not stalled; dump gives one result per entry, with
// last set on the final one. An empty list is answered without a walk.
// One item is in work at a time; in_stall is high during a walk and while a
// result waits under out_stall. A stall on the output pauses the walk.
// The asynchronous reset arst_n empties the list and drops any pending result;
// the record cells themselves are not cleared.
module ordered_record_list (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [orl_pkg::MODE_W-1:0]      mode,
	input  logic [orl_pkg::POS_W-1:0]       position,
	input  logic signed [orl_pkg::ID_W-1:0] record_id,
	input  logic [orl_pkg::GRADE_W-1:0]     record_grade,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [orl_pkg::STAT_W-1:0]      status,
	output logic                            found,
	output logic [orl_pkg::OCNT_W-1:0]      entry_count,
	output logic signed [orl_pkg::ID_W-1:0] out_id,
	output logic [orl_pkg::GRADE_W-1:0]     out_grade,
	output logic                            last
);

	orl_pkg::cell_cmd_t          cmd;
	logic [orl_pkg::ID_W-1:0]    cell_id    [orl_pkg::DEPTH];
	logic [orl_pkg::GRADE_W-1:0] cell_grade [orl_pkg::DEPTH];
	logic [orl_pkg::ID_W-1:0]    out_id_raw;

	// Operation decode and sequencing.
	orl_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.mode        (mode),
		.position    (position),
		.record_id   (record_id),
		.head_id     (cell_id[0]),
		.head_grade  (cell_grade[0]),
		.cmd         (cmd),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.status      (status),
		.found       (found),
		.entry_count (entry_count),
		.out_id      (out_id_raw),
		.out_grade   (out_grade),
		.last        (last)
	);

	assign out_id = out_id_raw;

	// Chain of cells; each sees its neighbors, the head cell and the new record.
	for (genvar g = 0; g < orl_pkg::DEPTH; g++) begin : g_cell
		logic [orl_pkg::ID_W-1:0]    l_id, r_id;
		logic [orl_pkg::GRADE_W-1:0] l_grade, r_grade;

		if (g == 0) begin : g_first
			assign l_id = '0;
			assign l_grade = '0;
		end else begin : g_mid_l
			assign l_id = cell_id[g-1];
			assign l_grade = cell_grade[g-1];
		end

		if (g == orl_pkg::DEPTH - 1) begin : g_final
			assign r_id = '0;
			assign r_grade = '0;
		end else begin : g_mid_r
			assign r_id = cell_id[g+1];
			assign r_grade = cell_grade[g+1];
		end

		orl_cell u_cell (
			.clk         (clk),
			.idx         (orl_pkg::IDX_W'(g)),
			.cmd         (cmd),
			.left_id     (l_id),
			.left_grade  (l_grade),
			.right_id    (r_id),
			.right_grade (r_grade),
			.head_id     (cell_id[0]),
			.head_grade  (cell_grade[0]),
			.new_id      (record_id),
			.new_grade   (record_grade),
			.id_q        (cell_id[g]),
			.grade_q     (cell_grade[g])
		);
	end

endmodule

>>> sv/orl_cell.sv
// One list cell: holds a record and takes a neighbor's, the head's or the new record on command.
module orl_cell (
	input  logic                            clk,
	input  logic [orl_pkg::IDX_W-1:0]       idx,
	input  orl_pkg::cell_cmd_t              cmd,
	input  logic [orl_pkg::ID_W-1:0]        left_id,
	input  logic [orl_pkg::GRADE_W-1:0]     left_grade,
	input  logic [orl_pkg::ID_W-1:0]        right_id,
	input  logic [orl_pkg::GRADE_W-1:0]     right_grade,
	input  logic [orl_pkg::ID_W-1:0]        head_id,
	input  logic [orl_pkg::GRADE_W-1:0]     head_grade,
	input  logic [orl_pkg::ID_W-1:0]        new_id,
	input  logic [orl_pkg::GRADE_W-1:0]     new_grade,
	output logic [orl_pkg::ID_W-1:0]        id_q,
	output logic [orl_pkg::GRADE_W-1:0]     grade_q
);

	logic [orl_pkg::ID_W-1:0]    id_d;
	logic [orl_pkg::GRADE_W-1:0] grade_d;

	// Pick the source of this cell's next record from its place relative to k, or to last_idx for a rotation.
	always_comb begin
		id_d = id_q;
		grade_d = grade_q;
		case (cmd.op)
			orl_pkg::CELL_INS: begin
				if (idx == cmd.k) begin
					id_d = new_id;
					grade_d = new_grade;
				end else if (idx > cmd.k) begin
					id_d = left_id;
					grade_d = left_grade;
				end
			end
			orl_pkg::CELL_DEL: begin
				if (idx >= cmd.k) begin
					id_d = right_id;
					grade_d = right_grade;
				end
			end
			orl_pkg::CELL_ROT: begin
				if (idx == cmd.last_idx) begin
					id_d = head_id;
					grade_d = head_grade;
				end else if (idx < cmd.last_idx) begin
					id_d = right_id;
					grade_d = right_grade;
				end
			end
			default: begin
			end
		endcase
	end

	// Record storage needs no reset: only cells below the length are read.
	always_ff @(posedge clk) begin
		id_q <= id_d;
		grade_q <= grade_d;
	end

endmodule

>>> sv/orl_ctrl.sv
// Controller: length, operation decode, walk sequencing and the result register.
module orl_ctrl (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [orl_pkg::MODE_W-1:0]      mode,
	input  logic [orl_pkg::POS_W-1:0]       position,
	input  logic [orl_pkg::ID_W-1:0]        record_id,
	input  logic [orl_pkg::ID_W-1:0]        head_id,
	input  logic [orl_pkg::GRADE_W-1:0]     head_grade,
	output orl_pkg::cell_cmd_t              cmd,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [orl_pkg::STAT_W-1:0]      status,
	output logic                            found,
	output logic [orl_pkg::OCNT_W-1:0]      entry_count,
	output logic [orl_pkg::ID_W-1:0]        out_id,
	output logic [orl_pkg::GRADE_W-1:0]     out_grade,
	output logic                            last
);

	orl_pkg::state_t             state_q, state_d;
	logic [orl_pkg::CNT_W-1:0]   len_q, len_d;
	logic [orl_pkg::IDX_W-1:0]   cnt_q, cnt_d;
	logic                        dump_q, dump_d;
	logic [orl_pkg::ID_W-1:0]    key_q, key_d;
	logic                        found_q, found_d;

	logic                        ov_q;
	orl_pkg::status_t            status_q;
	logic                        found_o_q;
	logic [orl_pkg::OCNT_W-1:0]  count_o_q;
	logic [orl_pkg::ID_W-1:0]    id_o_q;
	logic [orl_pkg::GRADE_W-1:0] grade_o_q;
	logic                        last_o_q;

	logic                        slot_free;
	logic                        acc;
	logic                        full;
	logic                        empty;
	logic                        hit;
	logic                        fin;
	logic [orl_pkg::IDX_W-1:0]   last_idx;
	logic [orl_pkg::IDX_W-1:0]   pos_idx;
	logic [orl_pkg::CMP_W-1:0]   pos_w;
	logic [orl_pkg::CMP_W-1:0]   len_w;

	logic                        ld;
	orl_pkg::status_t            r_status;
	logic                        r_found;
	logic [orl_pkg::ID_W-1:0]    r_id;
	logic [orl_pkg::GRADE_W-1:0] r_grade;
	logic                        r_last;

	// Shared decode terms.
	assign slot_free = !ov_q || !out_stall;
	assign in_stall = !((state_q == orl_pkg::ST_IDLE) && slot_free);
	assign acc = in_valid && !in_stall;
	assign full = (len_q >= orl_pkg::CNT_W'(orl_pkg::DEPTH));
	assign empty = (len_q == '0);
	assign last_idx = orl_pkg::IDX_W'(len_q - orl_pkg::CNT_W'(1));
	assign pos_idx = orl_pkg::IDX_W'(position - orl_pkg::POS_W'(1));
	assign pos_w = orl_pkg::CMP_W'(position);
	assign len_w = orl_pkg::CMP_W'(len_q);
	assign hit = (head_id == key_q);
	assign fin = (cnt_q == last_idx);

	// Next state, cell command and result for each operation.
	always_comb begin
		state_d = state_q;
		len_d = len_q;
		cnt_d = cnt_q;
		dump_d = dump_q;
		key_d = key_q;
		found_d = found_q;
		cmd.op = orl_pkg::CELL_HOLD;
		cmd.k = '0;
		cmd.last_idx = last_idx;
		ld = 1'b0;
		r_status = orl_pkg::STAT_OK;
		r_found = 1'b0;
		r_id = '0;
		r_grade = '0;
		r_last = 1'b1;

		if (state_q == orl_pkg::ST_IDLE) begin
			if (acc) begin
				ld = 1'b1;
				case (orl_pkg::mode_t'(mode))
					orl_pkg::MODE_CLEAR: begin
						len_d = '0;
					end
					orl_pkg::MODE_INS_FRONT, orl_pkg::MODE_INS_BACK: begin
						if (full) begin
							r_status = orl_pkg::STAT_FULL;
						end else begin
							cmd.op = orl_pkg::CELL_INS;
							cmd.k = (orl_pkg::mode_t'(mode) == orl_pkg::MODE_INS_FRONT) ?
								'0 : orl_pkg::IDX_W'(len_q);
							len_d = len_q + orl_pkg::CNT_W'(1);
						end
					end
					orl_pkg::MODE_INS_AT: begin
						if (full) begin
							r_status = orl_pkg::STAT_FULL;
						end else if (position == '0 ||
								pos_w > len_w + orl_pkg::CMP_W'(1)) begin
							r_status = orl_pkg::STAT_RANGE;
						end else begin
							cmd.op = orl_pkg::CELL_INS;
							cmd.k = pos_idx;
							len_d = len_q + orl_pkg::CNT_W'(1);
						end
					end
					orl_pkg::MODE_DEL_FRONT, orl_pkg::MODE_DEL_BACK: begin
						if (empty) begin
							r_status = orl_pkg::STAT_EMPTY;
						end else begin
							cmd.op = orl_pkg::CELL_DEL;
							cmd.k = (orl_pkg::mode_t'(mode) == orl_pkg::MODE_DEL_FRONT) ?
								'0 : last_idx;
							len_d = len_q - orl_pkg::CNT_W'(1);
						end
					end
					orl_pkg::MODE_DEL_AT: begin
						if (empty) begin
							r_status = orl_pkg::STAT_EMPTY;
						end else if (position == '0 || pos_w > len_w) begin
							r_status = orl_pkg::STAT_RANGE;
						end else begin
							cmd.op = orl_pkg::CELL_DEL;
							cmd.k = pos_idx;
							len_d = len_q - orl_pkg::CNT_W'(1);
						end
					end
					orl_pkg::MODE_SEARCH, orl_pkg::MODE_DUMP: begin
						if (empty) begin
							if (orl_pkg::mode_t'(mode) == orl_pkg::MODE_DUMP) begin
								r_status = orl_pkg::STAT_EMPTY;
							end
						end else begin
							// Walk the list by rotating it once through the head cell.
							ld = 1'b0;
							state_d = orl_pkg::ST_WALK;
							cnt_d = '0;
							found_d = 1'b0;
							key_d = record_id;
							dump_d = (orl_pkg::mode_t'(mode) == orl_pkg::MODE_DUMP);
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			// One rotation step per cycle while the result register can take a value.
			if (slot_free) begin
				cmd.op = orl_pkg::CELL_ROT;
				found_d = found_q || hit;
				cnt_d = cnt_q + orl_pkg::IDX_W'(1);
				if (dump_q) begin
					ld = 1'b1;
					r_id = head_id;
					r_grade = head_grade;
					r_last = fin;
				end else if (fin) begin
					ld = 1'b1;
					r_found = found_q || hit;
				end
				if (fin) begin
					state_d = orl_pkg::ST_IDLE;
				end
			end
		end
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= orl_pkg::ST_IDLE;
			len_q <= '0;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			len_q <= len_d;
			if (ld) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
		end
	end

	// Walk bookkeeping and the result payload.
	always_ff @(posedge clk) begin
		cnt_q <= cnt_d;
		dump_q <= dump_d;
		key_q <= key_d;
		found_q <= found_d;
		if (ld) begin
			status_q <= r_status;
			found_o_q <= r_found;
			count_o_q <= orl_pkg::OCNT_W'(len_d);
			id_o_q <= r_id;
			grade_o_q <= r_grade;
			last_o_q <= r_last;
		end
	end

	assign out_valid = ov_q;
	assign status = status_q;
	assign found = found_o_q;
	assign entry_count = count_o_q;
	assign out_id = id_o_q;
	assign out_grade = grade_o_q;
	assign last = last_o_q;

`ifndef SYNTH
	// The length never exceeds the capacity.
	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= orl_pkg::CNT_W'(orl_pkg::DEPTH))
		else $error("list length above capacity");

	// A walk only runs over a non-empty list and stays within it.
	a_walk_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == orl_pkg::ST_WALK |-> (!empty && cnt_q <= last_idx))
		else $error("walk outside the list");

	// The list length does not change during a walk.
	a_walk_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == orl_pkg::ST_WALK |=> $stable(len_q))
		else $error("length changed during a walk");

	// A waiting result is not overwritten while the receiver stalls.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && out_stall) |-> !ld)
		else $error("result overwritten under stall");
`endif

endmodule
